/* src/selective_repeat_receiver_window_top_defines.svh */
// Assertion macros for the receive window block.
`ifndef SELECTIVE_REPEAT_RECEIVER_WINDOW_TOP_DEFINES_SVH
`define SELECTIVE_REPEAT_RECEIVER_WINDOW_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRRW_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SRRW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/srrw_pkg.sv */
`default_nettype none

package srrw_pkg;

    localparam int MAX_WINDOW = 64;
    localparam int IDX_W      = $clog2(MAX_WINDOW);

    localparam logic [1:0] CFG_SEQ_BITS    = 2'd0;
    localparam logic [1:0] CFG_WINDOW_SIZE = 2'd1;
    localparam logic [1:0] CFG_BUF_LIMIT   = 2'd2;
    localparam logic [1:0] CFG_TOTAL_PKTS  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SLIDE_RD,
        ST_SLIDE_CHK,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

/* src/selective_repeat_receiver_window_top.sv */
`default_nettype none

// Selective-repeat receive window. Each input word carries the sequence number of one
// arriving packet. Each word produces exactly one result word with the acknowledge flag,
// the number of packets released in order by the window slide, and a transfer-done flag.
// The receive marks live in a 64-entry memory with a registered read, so every
// slot visit is a read followed by a check. A dropped word goes from acceptance through
// the check straight to the emit step that loads its result into the output register.
// An acknowledged word first writes its mark; the slide then reads each leading marked
// slot and makes one final read that ends it, before the emit step. The next word is
// accepted after that load at the earliest, once the block is back in idle. A result may
// wait on m_tready while the next word is already being worked on. That word then holds in
// its last step until the output register is free. Configuration writes belong in idle periods.
module selective_repeat_receiver_window_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [14:0] seq_number
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // [0] ack, [7:1] slid_count, [8] transfer_done
);

    `include "selective_repeat_receiver_window_top_defines.svh"

    localparam int IW = srrw_pkg::IDX_W;

    logic [4:0]  cfg_seq_bits_reg;
    logic [6:0]  cfg_win_size_reg;
    logic [6:0]  cfg_buf_limit_reg;
    logic [15:0] cfg_total_reg;

    srrw_pkg::state_t state_reg, state_next;
    logic [15:0] base_reg, base_next;
    logic [6:0]  held_reg, held_next;
    logic [15:0] rx_total_reg, rx_total_next;
    logic        elig_reg, elig_next;
    logic        ack_reg, ack_next;
    logic [6:0]  slid_reg, slid_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic        out_ack_reg, out_ack_next;
    logic [6:0]  out_slid_reg, out_slid_next;
    logic        out_done_reg, out_done_next;

    logic                        mark_mem [srrw_pkg::MAX_WINDOW];
    logic [srrw_pkg::MAX_WINDOW-1:0] valid_reg;
    logic                        mem_rdata_reg;
    logic [IW-1:0]               rd_addr_reg;
    logic                        mem_we, mem_wdata, mem_re;
    logic [IW-1:0]               mem_waddr, mem_raddr;
    logic                        mark;

    logic [4:0]  seq_bits;
    logic [15:0] mask;
    logic [15:0] seq16;
    logic [15:0] expected;
    logic        blocked, in_space, in_window, not_done;
    logic [6:0]  win_clamped;
    logic [15:0] left;
    logic [6:0]  win_width;
    logic [15:0] slot_j;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_seq_bits_reg  <= 5'd8;
            cfg_win_size_reg  <= 7'd8;
            cfg_buf_limit_reg <= 7'd8;
            cfg_total_reg     <= 16'd1000;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                srrw_pkg::CFG_SEQ_BITS:    cfg_seq_bits_reg  <= cfg_data[4:0];
                srrw_pkg::CFG_WINDOW_SIZE: cfg_win_size_reg  <= cfg_data[6:0];
                srrw_pkg::CFG_BUF_LIMIT:   cfg_buf_limit_reg <= cfg_data[6:0];
                srrw_pkg::CFG_TOTAL_PKTS:  cfg_total_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mark_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_rdata_reg <= mark_mem[mem_raddr];
            rd_addr_reg   <= mem_raddr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (mem_we) begin
            valid_reg[mem_waddr] <= 1'b1;
        end
    end

    assign mark = valid_reg[rd_addr_reg] & mem_rdata_reg;

    always_comb begin
        if (cfg_seq_bits_reg < 5'd2) begin
            seq_bits = 5'd2;
        end else if (cfg_seq_bits_reg > 5'd16) begin
            seq_bits = 5'd16;
        end else begin
            seq_bits = cfg_seq_bits_reg;
        end
        if (cfg_win_size_reg < 7'd1) begin
            win_clamped = 7'd1;
        end else if (cfg_win_size_reg > 7'(srrw_pkg::MAX_WINDOW)) begin
            win_clamped = 7'(srrw_pkg::MAX_WINDOW);
        end else begin
            win_clamped = cfg_win_size_reg;
        end
        mask      = (16'd1 << 4'(seq_bits - 5'd1)) - 16'd1;
        seq16     = {1'b0, s_tdata[14:0]};
        expected  = base_reg & mask;
        blocked   = (held_reg >= cfg_buf_limit_reg) && (seq16 != expected);
        in_space  = (seq16 & ~mask) == 16'd0;
        left      = (cfg_total_reg > base_reg) ? (cfg_total_reg - base_reg) : 16'd0;
        win_width = ({9'd0, win_clamped} < left) ? win_clamped : left[6:0];
        slot_j    = (seq16 - base_reg) & mask;
        in_window = slot_j < {9'd0, win_width};
        not_done  = rx_total_reg < cfg_total_reg;
    end

    always_comb begin
        state_next    = state_reg;
        base_next     = base_reg;
        held_next     = held_reg;
        rx_total_next = rx_total_reg;
        elig_next     = elig_reg;
        ack_next      = ack_reg;
        slid_next     = slid_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        out_ack_next  = out_ack_reg;
        out_slid_next = out_slid_reg;
        out_done_next = out_done_reg;
        mem_we        = 1'b0;
        mem_wdata     = 1'b0;
        mem_waddr     = base_reg[IW-1:0];
        mem_re        = 1'b0;
        mem_raddr     = base_reg[IW-1:0];
        s_tready      = 1'b0;

        case (state_reg)
            srrw_pkg::ST_IDLE: begin
                s_tready  = 1'b1;
                mem_raddr = base_reg[IW-1:0] + slot_j[IW-1:0];
                if (s_tvalid) begin
                    mem_re     = 1'b1;
                    elig_next  = not_done && !blocked && in_space && in_window;
                    ack_next   = 1'b0;
                    slid_next  = 7'd0;
                    state_next = srrw_pkg::ST_CHECK;
                end
            end
            srrw_pkg::ST_CHECK: begin
                if (elig_reg && !mark) begin
                    mem_we        = 1'b1;
                    mem_wdata     = 1'b1;
                    mem_waddr     = rd_addr_reg;
                    held_next     = held_reg + 7'd1;
                    rx_total_next = rx_total_reg + 16'd1;
                    ack_next      = 1'b1;
                    state_next    = srrw_pkg::ST_SLIDE_RD;
                end else begin
                    state_next = srrw_pkg::ST_EMIT;
                end
            end
            srrw_pkg::ST_SLIDE_RD: begin
                mem_re     = 1'b1;
                state_next = srrw_pkg::ST_SLIDE_CHK;
            end
            srrw_pkg::ST_SLIDE_CHK: begin
                if ((base_reg < cfg_total_reg) && mark) begin
                    mem_we    = 1'b1;
                    mem_wdata = 1'b0;
                    base_next = base_reg + 16'd1;
                    if (held_reg != 7'd0) begin
                        held_next = held_reg - 7'd1;
                    end
                    if (slid_reg != 7'd127) begin
                        slid_next = slid_reg + 7'd1;
                    end
                    state_next = srrw_pkg::ST_SLIDE_RD;
                end else begin
                    state_next = srrw_pkg::ST_EMIT;
                end
            end
            srrw_pkg::ST_EMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    out_ack_next  = ack_reg;
                    out_slid_next = slid_reg;
                    out_done_next = rx_total_reg >= cfg_total_reg;
                    state_next    = srrw_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = srrw_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= srrw_pkg::ST_IDLE;
            base_reg     <= 16'd0;
            held_reg     <= 7'd0;
            rx_total_reg <= 16'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            base_reg     <= base_next;
            held_reg     <= held_next;
            rx_total_reg <= rx_total_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        elig_reg     <= elig_next;
        ack_reg      <= ack_next;
        slid_reg     <= slid_next;
        out_ack_reg  <= out_ack_next;
        out_slid_reg <= out_slid_next;
        out_done_reg <= out_done_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, out_done_reg, out_slid_reg, out_ack_reg};

    `SRRW_ASSERT_SAME(a_mem_port_exclusive, mem_we, !mem_re,
        "Mark memory read and write issued in the same cycle.")
    `SRRW_ASSERT_SAME(a_held_bound, 1'b1, held_reg <= 7'(srrw_pkg::MAX_WINDOW),
        "Held packet count exceeds the window capacity.")
    `SRRW_ASSERT_SAME(a_slide_needs_ack, m_tvalid, (m_tdata[7:1] == 7'd0) || m_tdata[0],
        "Window slid on a word that was not acknowledged.")
    `SRRW_ASSERT_NEXT(a_accept_to_check, s_tvalid && s_tready,
        state_reg == srrw_pkg::ST_CHECK,
        "Accepted word did not move on to the mark check.")

endmodule

`default_nettype wire

/* tb/tb_selective_repeat_receiver_window_top.sv */
`timescale 1ns / 1ps

module tb_selective_repeat_receiver_window_top;

    localparam int STALL_LIMIT = 5000;

    typedef struct packed {
        logic       ack;
        logic [6:0] slid;
        logic       done;
    } window_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = srrw_pkg::CFG_SEQ_BITS;
    logic [15:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;    // [14:0] seq_number
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // [0] ack, [7:1] slid_count, [8] transfer_done

    selective_repeat_receiver_window_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Shadow of the receive window.
    int unsigned r_seq_bits = 8;
    int unsigned r_window   = 8;
    int unsigned r_buf_lim  = 8;
    int unsigned r_total    = 1000;
    int unsigned rx_base    = 0;
    int unsigned rx_held    = 0;
    int unsigned rx_total   = 0;
    logic        rx_marks [srrw_pkg::MAX_WINDOW];

    logic [14:0]    seq_q [$];
    window_result_t result_q [$];
    int unsigned    words_taken = 0;
    int unsigned    outstanding = 0;
    int unsigned    stall_cycles = 0;
    int unsigned    mismatches = 0;
    logic           s_fire = 1'b0;

    initial begin
        foreach (rx_marks[i]) rx_marks[i] = 1'b0;
    end

    function automatic int unsigned seq_space_mask();
        int unsigned bits;
        bits = (r_seq_bits < 2) ? 2 : ((r_seq_bits > 16) ? 16 : r_seq_bits);
        return (32'd1 << (bits - 1)) - 1;
    endfunction

    function automatic int unsigned window_limit();
        return (r_window < 1) ? 1 :
               ((r_window > srrw_pkg::MAX_WINDOW) ? srrw_pkg::MAX_WINDOW : r_window);
    endfunction

    function automatic window_result_t advance_window(input logic [14:0] seq);
        window_result_t r;
        int unsigned mask, left, w, j, s, slot;
        logic blocked;
        r = '0;
        s = 32'(seq);
        if (rx_total < r_total) begin
            mask = seq_space_mask();
            blocked = (rx_held >= r_buf_lim) && (s != (rx_base & mask));
            if (!blocked && s <= mask) begin
                left = (r_total > rx_base) ? r_total - rx_base : 0;
                w = (window_limit() < left) ? window_limit() : left;
                j = (s - rx_base) & mask;
                slot = (rx_base + j) % srrw_pkg::MAX_WINDOW;
                if (j < w && !rx_marks[slot]) begin
                    rx_marks[slot] = 1'b1;
                    rx_held++;
                    rx_total++;
                    r.ack = 1'b1;
                    while (rx_base < r_total && rx_marks[rx_base % srrw_pkg::MAX_WINDOW]) begin
                        rx_marks[rx_base % srrw_pkg::MAX_WINDOW] = 1'b0;
                        rx_base++;
                        if (rx_held > 0) rx_held--;
                        if (r.slid < 7'd127) r.slid = r.slid + 7'd1;
                    end
                end
            end
        end
        r.done = (rx_total >= r_total);
        return r;
    endfunction

    // Mostly packets around the window base, some behind it, some noise.
    function automatic logic [14:0] pick_seq();
        int unsigned mask, ws, roll;
        mask = seq_space_mask();
        ws = window_limit();
        roll = $urandom_range(0, 99);
        if (roll < 35) return 15'(rx_base & mask);
        if (roll < 75) return 15'((rx_base + $urandom_range(1, ws)) & mask);
        if (roll < 85) return 15'((rx_base - $urandom_range(1, ws)) & mask);
        if (roll < 93) return 15'($urandom_range(0, mask));
        return 15'($urandom_range(0, 32767));
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (mismatches < 40)
            $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    always @(negedge aclk) begin : drive
        int unsigned send_idle, recv_idle;
        if (words_taken < 150) begin
            send_idle = 37;
            recv_idle = 80;
        end else if (words_taken < 300) begin
            send_idle = 80;
            recv_idle = 37;
        end else begin
            send_idle = 0;
            recv_idle = 0;
        end
        if (aresetn) begin
            if (!s_tvalid || s_fire) begin
                if (seq_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
                    s_tdata <= {1'b0, seq_q.pop_front()};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    always @(posedge aclk) begin : watch
        window_result_t want;
        logic in_fire, out_fire;
        in_fire = s_tvalid && s_tready;
        out_fire = m_tvalid && m_tready;
        if (aresetn) begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    srrw_pkg::CFG_SEQ_BITS:    r_seq_bits = 32'(cfg_data[4:0]);
                    srrw_pkg::CFG_WINDOW_SIZE: r_window = 32'(cfg_data[6:0]);
                    srrw_pkg::CFG_BUF_LIMIT:   r_buf_lim = 32'(cfg_data[6:0]);
                    srrw_pkg::CFG_TOTAL_PKTS:  r_total = 32'(cfg_data);
                    default: ;
                endcase
            end
            if (in_fire) begin
                result_q = {result_q, advance_window(s_tdata[14:0])};
                words_taken++;
            end
            if (out_fire) begin
                if (result_q.size() == 0) begin
                    report_mismatch("unexpected result word", m_tdata, 0);
                end else begin
                    want = result_q.pop_front();
                    if (m_tdata[0] !== want.ack)
                        report_mismatch("ack", m_tdata[0], want.ack);
                    if (m_tdata[7:1] !== want.slid)
                        report_mismatch("slid_count", m_tdata[7:1], want.slid);
                    if (m_tdata[8] !== want.done)
                        report_mismatch("transfer_done", m_tdata[8], want.done);
                end
            end
            outstanding <= outstanding + in_fire - out_fire;
            s_fire <= in_fire;
            stall_cycles <= (in_fire || out_fire || cfg_wr_en) ? 0 : stall_cycles + 1;
        end
    end

    always @(posedge aclk) begin
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_selective_repeat_receiver_window_top: FAIL");
            $finish;
        end
    end

    task automatic wait_idle();
        do @(posedge aclk); while (seq_q.size() != 0 || s_tvalid || outstanding != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic configure(input int unsigned sb, input int unsigned ws,
                             input int unsigned bl, input int unsigned tp,
                             input bit relative);
        int unsigned total;
        wait_idle();
        total = tp;
        if (relative) total = (rx_total + tp > 65535) ? 65535 : rx_total + tp;
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= srrw_pkg::CFG_SEQ_BITS;
        cfg_data <= 16'(sb);
        @(negedge aclk);
        cfg_index <= srrw_pkg::CFG_WINDOW_SIZE;
        cfg_data <= 16'(ws);
        @(negedge aclk);
        cfg_index <= srrw_pkg::CFG_BUF_LIMIT;
        cfg_data <= 16'(bl);
        @(negedge aclk);
        cfg_index <= srrw_pkg::CFG_TOTAL_PKTS;
        cfg_data <= 16'(total);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_traffic(input int n);
        repeat (n) begin
            @(negedge aclk);
            while (seq_q.size() >= 2) @(negedge aclk);
            seq_q = {seq_q, pick_seq()};
        end
    endtask

    initial begin : main
        logic [14:0] opening [20];
        int unsigned b;
        opening = '{15'd0, 15'd0, 15'd2, 15'd3, 15'd1, 15'd127, 15'd128, 15'h7FFF,
                    15'd5, 15'd6, 15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12,
                    15'd4, 15'd4, 15'h5555, 15'h2AAA};
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        foreach (opening[i]) seq_q = {seq_q, opening[i]};

        configure(2, 1, 0, 30, 1'b1);
        send_traffic(40);

        configure(16, 64, 64, 65535, 1'b0);
        @(negedge aclk);
        b = rx_base;
        for (int k = 63; k >= 0; k--) seq_q = {seq_q, 15'((b + 32'(k)) & 32'h7FFF)};
        send_traffic(30);

        configure(0, 0, 127, 25, 1'b1);
        send_traffic(35);

        configure(31, 127, 3, 200, 1'b1);
        send_traffic(80);

        configure(5, 20, 5, 60, 1'b1);
        send_traffic(60);

        configure(6, 16, 64, 1, 1'b0);
        send_traffic(5);

        configure(1, 65, 65, 80, 1'b1);
        send_traffic(60);

        configure(12, 33, 10, 100, 1'b1);
        send_traffic(60);

        wait_idle();
        repeat (150) @(posedge aclk);
        if (mismatches == 0 && result_q.size() == 0) begin
            $display("tb_selective_repeat_receiver_window_top: PASS");
        end else begin
            $display("tb_selective_repeat_receiver_window_top: FAIL");
        end
        $finish;
    end

endmodule
